@@ hdl/tbp_pkg.sv @@
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types and constants of the track box post-processor.
// ----------------------------------------------------------------------------
package tbp_pkg;

  localparam int FRAME_W  = 24;
  localparam int COORD_W  = 32;
  localparam int SCORE_W  = 17;
  localparam int STRIDE_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Q1.16 unity
  localparam logic [SCORE_W-1:0] Q_ONE = 17'd65536;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);

  // Result kinds
  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_RANGE = 1'b1;

  // Box lane order
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_W = 2;
  localparam int LANE_H = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOST_THRESHOLD   = 3'd0,
    REG_HOLD_ENABLE      = 3'd1,
    REG_SMOOTHING_WEIGHT = 3'd2,
    REG_TRACK_SIZE       = 3'd3,
    REG_KEY_INTERVAL     = 3'd4
  } reg_idx_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [3:0] box_t;

  typedef struct packed {
    logic [SCORE_W-1:0]  lost_threshold;
    logic                hold_enable;
    logic [SCORE_W-1:0]  smoothing_weight;
    logic                track_size;
    logic [STRIDE_W-1:0] key_interval;
  } cfg_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    box_t               box;
    logic [SCORE_W-1:0] score;
    logic               final_sample;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic [FRAME_W-1:0] frame_start;
    logic [FRAME_W-1:0] frame_end;
    box_t               box;
    logic               run_last;
  } result_t;

  // Up to two results produced by one sample, in delivery order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

@@ hdl/track_box_postprocessor.sv @@
// ----------------------------------------------------------------------------
// track_box_postprocessor
// Tracker sample post-processing: loss detection, box hold, smoothing,
// keyframe and lost-range results.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  input   | in_valid / in_stall    | frame_number, box_x..box_h, score,
//          |                        | final_sample
//  output  | out_valid / out_stall  | kind, frame_start, frame_end,
//          |                        | out_x..out_h, run_last
//  config  | cfg_we                 | cfg_index, cfg_data
//
//  A sample lands in the input register at its transaction and is processed
//  once the queue has room; its results enter the result queue at the
//  following edge, which raises out_valid. One sample per cycle is sustained
//  while each gives at most one result and the output does not stall; a
//  sample with two results gives them out one after the other, absorbed by
//  the four-entry result queue, which admits a sample only with room for two
//  results. Synchronous reset restores the register reset values and clears
//  all track state at once; no clearing pass is needed. A stalled output
//  holds its head entry; a queue holding more than two results stalls the
//  input while a sample is held.
// ----------------------------------------------------------------------------
module track_box_postprocessor (
  input  logic                               clk,
  input  logic                               rst,

  input  logic                               cfg_we,
  input  logic [tbp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbp_pkg::CFG_DATA_W-1:0]     cfg_data,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tbp_pkg::FRAME_W-1:0]        frame_number,
  input  logic signed [tbp_pkg::COORD_W-1:0] box_x,
  input  logic signed [tbp_pkg::COORD_W-1:0] box_y,
  input  logic signed [tbp_pkg::COORD_W-1:0] box_w,
  input  logic signed [tbp_pkg::COORD_W-1:0] box_h,
  input  logic [tbp_pkg::SCORE_W-1:0]        score,
  input  logic                               final_sample,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               kind,
  output logic [tbp_pkg::FRAME_W-1:0]        frame_start,
  output logic [tbp_pkg::FRAME_W-1:0]        frame_end,
  output logic signed [tbp_pkg::COORD_W-1:0] out_x,
  output logic signed [tbp_pkg::COORD_W-1:0] out_y,
  output logic signed [tbp_pkg::COORD_W-1:0] out_w,
  output logic signed [tbp_pkg::COORD_W-1:0] out_h,
  output logic                               run_last
);

  tbp_pkg::cfg_t                 cfg;
  tbp_pkg::item_t                item;
  logic                          pending;
  logic                          fire;
  logic                          in_take;
  tbp_pkg::push_t                push;
  tbp_pkg::result_t              head;
  logic [tbp_pkg::LEVEL_W-1:0]   level;

  // Configuration registers: apply a write on the enable, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lost_threshold   <= 17'd32768;
      cfg.hold_enable      <= 1'b1;
      cfg.smoothing_weight <= '0;
      cfg.track_size       <= 1'b1;
      cfg.key_interval     <= tbp_pkg::STRIDE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tbp_pkg::REG_LOST_THRESHOLD:   cfg.lost_threshold   <= cfg_data;
        tbp_pkg::REG_HOLD_ENABLE:      cfg.hold_enable      <= cfg_data[0];
        tbp_pkg::REG_SMOOTHING_WEIGHT: cfg.smoothing_weight <= cfg_data;
        tbp_pkg::REG_TRACK_SIZE:       cfg.track_size       <= cfg_data[0];
        tbp_pkg::REG_KEY_INTERVAL:
          cfg.key_interval <= cfg_data[tbp_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Process the held sample only when the queue can take both of its results
  assign fire     = pending && (level <= tbp_pkg::LEVEL_W'(tbp_pkg::FIFO_DEPTH - 2));
  assign in_stall = pending && !fire;
  assign in_take  = in_valid && !in_stall;

  // Input register: load on each transaction, drop the sample once processed
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (in_take) begin
      pending <= 1'b1;
    end else if (fire) begin
      pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.frame_number <= frame_number;
      item.box          <= {box_h, box_w, box_y, box_x};
      item.score        <= score;
      item.final_sample <= final_sample;
    end
  end

  tbp_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (fire),
    .item (item),
    .push (push)
  );

  tbp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (!out_stall),
    .head       (head),
    .head_valid (out_valid),
    .level      (level)
  );

  // Present the queue head
  assign kind        = head.kind;
  assign frame_start = head.frame_start;
  assign frame_end   = head.frame_end;
  assign out_x       = head.box[tbp_pkg::LANE_X];
  assign out_y       = head.box[tbp_pkg::LANE_Y];
  assign out_w       = head.box[tbp_pkg::LANE_W];
  assign out_h       = head.box[tbp_pkg::LANE_H];
  assign run_last    = head.run_last;

  // Queue never overfills
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= tbp_pkg::LEVEL_W'(tbp_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  // A processed sample with results makes the output valid next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |=> out_valid)
    else $error("results pushed but output not valid");

  // A pair of results closes on the second only
  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (!push.first.run_last && push.second.run_last))
    else $error("run_last misplaced in a result pair");

  // Only a processed sample pushes results
  a_push_fire: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> fire)
    else $error("results pushed without a sample");

endmodule

@@ hdl/tbp_ema.sv @@
// ----------------------------------------------------------------------------
// tbp_ema
// One lane of the moving average: ((1 - s) * box + s * prev), floored.
// ----------------------------------------------------------------------------
module tbp_ema (
  input  logic [tbp_pkg::SCORE_W-1:0] weight,
  input  tbp_pkg::coord_t             box,
  input  tbp_pkg::coord_t             prev,
  output tbp_pkg::coord_t             blended
);

  logic [tbp_pkg::SCORE_W-1:0] inv_weight;
  logic signed [49:0]          prod_new;
  logic signed [49:0]          prod_old;
  logic signed [50:0]          acc;

  assign inv_weight = tbp_pkg::Q_ONE - weight;
  assign prod_new   = $signed({1'b0, inv_weight}) * box;
  assign prod_old   = $signed({1'b0, weight}) * prev;
  assign acc        = {prod_new[49], prod_new} + {prod_old[49], prod_old};

  // Result lies between box and prev, so the floored shift fits in 32 bits
  assign blended = acc[47:16];

endmodule

@@ hdl/tbp_core.sv @@
// ----------------------------------------------------------------------------
// tbp_core
// Per-sample track state: hold, smoothing, size pinning, keyframes, lost runs.
// ----------------------------------------------------------------------------
module tbp_core (
  input  logic            clk,
  input  logic            rst,
  input  tbp_pkg::cfg_t   cfg,
  input  logic            fire,
  input  tbp_pkg::item_t  item,
  output tbp_pkg::push_t  push
);

  tbp_pkg::box_t                 held_box;
  logic                          held_valid;
  tbp_pkg::box_t                 smoothed_box;
  tbp_pkg::coord_t               seed_width;
  tbp_pkg::coord_t               seed_height;
  logic [tbp_pkg::STRIDE_W-1:0]  stride_phase;
  logic                          at_track_start;
  logic                          in_lost_run;
  logic [tbp_pkg::FRAME_W-1:0]   run_start_frame;
  logic [tbp_pkg::FRAME_W-1:0]   prior_frame;

  logic                          lost;
  logic [tbp_pkg::SCORE_W-1:0]   weight;
  logic [tbp_pkg::STRIDE_W-1:0]  stride;
  logic [tbp_pkg::STRIDE_W:0]    phase_inc;
  logic [tbp_pkg::STRIDE_W-1:0]  stride_phase_next;
  tbp_pkg::box_t                 box_sel;
  tbp_pkg::box_t                 blended;
  tbp_pkg::box_t                 smoothed_box_next;
  tbp_pkg::box_t                 res_box;
  logic                          key;
  logic                          range_final;
  logic                          range_close;
  logic                          has_range;
  tbp_pkg::result_t              key_res;
  tbp_pkg::result_t              range_res;

  assign lost   = item.score < cfg.lost_threshold;
  assign weight = (cfg.smoothing_weight > tbp_pkg::Q_ONE) ? tbp_pkg::Q_ONE
                                                          : cfg.smoothing_weight;
  assign stride = (cfg.key_interval == '0) ? tbp_pkg::STRIDE_W'(1)
                                           : cfg.key_interval;

  assign box_sel = (lost && cfg.hold_enable && held_valid) ? held_box : item.box;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    tbp_ema u_ema (
      .weight  (weight),
      .box     (box_sel[k]),
      .prev    (smoothed_box[k]),
      .blended (blended[k])
    );
  end

  always_comb begin
    smoothed_box_next = at_track_start ? box_sel : blended;
    res_box           = smoothed_box_next;
    if (!cfg.track_size) begin
      res_box[tbp_pkg::LANE_W] = at_track_start ? item.box[tbp_pkg::LANE_W] : seed_width;
      res_box[tbp_pkg::LANE_H] = at_track_start ? item.box[tbp_pkg::LANE_H] : seed_height;
    end
  end

  // Keyframe cadence; a phase left beyond a lowered stride wraps to zero
  assign key               = (stride_phase == '0) || item.final_sample;
  assign phase_inc         = {1'b0, stride_phase} + (tbp_pkg::STRIDE_W + 1)'(1);
  assign stride_phase_next = (phase_inc >= {1'b0, stride}) ? '0
                                                           : phase_inc[tbp_pkg::STRIDE_W-1:0];

  assign range_final = lost && item.final_sample;
  assign range_close = !lost && in_lost_run;
  assign has_range   = range_final || range_close;

  always_comb begin
    key_res.kind        = tbp_pkg::KIND_KEY;
    key_res.frame_start = item.frame_number;
    key_res.frame_end   = '0;
    key_res.box         = res_box;
    key_res.run_last    = !has_range;

    range_res.kind        = tbp_pkg::KIND_RANGE;
    range_res.frame_start = in_lost_run ? run_start_frame : item.frame_number;
    range_res.frame_end   = range_final ? item.frame_number : prior_frame;
    range_res.box         = '0;
    range_res.run_last    = 1'b1;

    push.count  = fire ? ({1'b0, key} + {1'b0, has_range}) : 2'd0;
    push.first  = key ? key_res : range_res;
    push.second = range_res;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && item.final_sample)) begin
      held_box        <= '0;
      held_valid      <= 1'b0;
      smoothed_box    <= '0;
      seed_width      <= '0;
      seed_height     <= '0;
      stride_phase    <= '0;
      at_track_start  <= 1'b1;
      in_lost_run     <= 1'b0;
      run_start_frame <= '0;
      prior_frame     <= '0;
    end else if (fire) begin
      if (at_track_start) begin
        seed_width  <= item.box[tbp_pkg::LANE_W];
        seed_height <= item.box[tbp_pkg::LANE_H];
      end
      if (!lost) begin
        held_box   <= item.box;
        held_valid <= 1'b1;
      end
      if (lost && !in_lost_run) begin
        in_lost_run     <= 1'b1;
        run_start_frame <= item.frame_number;
      end else if (range_close) begin
        in_lost_run <= 1'b0;
      end
      smoothed_box   <= smoothed_box_next;
      stride_phase   <= stride_phase_next;
      at_track_start <= 1'b0;
      prior_frame    <= item.frame_number;
    end
  end

endmodule

@@ hdl/tbp_fifo.sv @@
// ----------------------------------------------------------------------------
// tbp_fifo
// Small result queue taking up to two results a cycle, giving one.
// ----------------------------------------------------------------------------
module tbp_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  tbp_pkg::push_t               push,
  input  logic                         pop,
  output tbp_pkg::result_t             head,
  output logic                         head_valid,
  output logic [tbp_pkg::LEVEL_W-1:0]  level
);

  tbp_pkg::result_t              mem [tbp_pkg::FIFO_DEPTH];
  logic [tbp_pkg::PTR_W-1:0]     wptr;
  logic [tbp_pkg::PTR_W-1:0]     rptr;
  logic [tbp_pkg::PTR_W-1:0]     wptr_second;
  logic [tbp_pkg::LEVEL_W-1:0]   level_next;
  logic                          pop_ok;

  assign head_valid  = (level != '0);
  assign head        = mem[rptr];
  assign pop_ok      = pop && head_valid;
  assign wptr_second = wptr + tbp_pkg::PTR_W'(1);
  assign level_next  = level + tbp_pkg::LEVEL_W'(push.count)
                             - tbp_pkg::LEVEL_W'(pop_ok);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wptr_second] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      wptr  <= wptr + tbp_pkg::PTR_W'(push.count);
      rptr  <= rptr + tbp_pkg::PTR_W'(pop_ok);
      level <= level_next;
    end
  end

endmodule

@@ tb/track_box_postprocessor_test.sv @@
// ----------------------------------------------------------------------------
// track_box_postprocessor_test
// Self-checking bench for the track box post-processor. A shadow predictor
// follows every accepted sample and queues the keyframe and lost-range
// results it should cause; each result leaving the block is checked against
// the oldest queued one. Directed tracks cover hold, pinning, smoothing,
// stride and threshold corner cases, then random tracks run under several
// register settings with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module track_box_postprocessor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES   = 8;      // time for the pipeline to empty, with margin
  localparam int LIMIT_CYCLES    = 400000;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_ITEMS     = 180;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_ITEMS  = 40;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
  } stall_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           cfg_we    = 1'b0;
  logic [tbp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tbp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic                        in_valid     = 1'b0;
  logic                        in_stall;
  logic [tbp_pkg::FRAME_W-1:0] frame_number = '0;
  tbp_pkg::coord_t             box_x        = '0;
  tbp_pkg::coord_t             box_y        = '0;
  tbp_pkg::coord_t             box_w        = '0;
  tbp_pkg::coord_t             box_h        = '0;
  logic [tbp_pkg::SCORE_W-1:0] score        = '0;
  logic                        final_sample = 1'b0;

  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        kind;
  logic [tbp_pkg::FRAME_W-1:0] frame_start;
  logic [tbp_pkg::FRAME_W-1:0] frame_end;
  tbp_pkg::coord_t             out_x, out_y, out_w, out_h;
  logic                        run_last;

  track_box_postprocessor u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .frame_number (frame_number),
    .box_x        (box_x),
    .box_y        (box_y),
    .box_w        (box_w),
    .box_h        (box_h),
    .score        (score),
    .final_sample (final_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .frame_start  (frame_start),
    .frame_end    (frame_end),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_w        (out_w),
    .out_h        (out_h),
    .run_last     (run_last)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the registers and the track state, at their reset values
  // --------------------------------------------------------------------------
  tbp_pkg::cfg_t                regs = {17'd32768, 1'b1, 17'd0, 1'b1, 16'd1};
  tbp_pkg::box_t                held_raw   = '0;
  logic                         held_ok    = 1'b0;
  tbp_pkg::box_t                smooth_box = '0;
  tbp_pkg::coord_t              seed_w     = '0;
  tbp_pkg::coord_t              seed_h     = '0;
  logic [tbp_pkg::STRIDE_W-1:0] kf_phase   = '0;
  logic                         track_open = 1'b1;   // next sample starts a track
  logic                         in_run     = 1'b0;
  logic [tbp_pkg::FRAME_W-1:0]  run_first  = '0;
  logic [tbp_pkg::FRAME_W-1:0]  last_frame = '0;

  tbp_pkg::result_t outstanding_results[$];
  tbp_pkg::result_t got_want;
  int      mismatches    = 0;
  int      cycles        = 0;
  int      burst_left    = 0;
  int      hold_off_asks = 0;

  // Work out what one accepted sample should produce and queue it in order:
  // keyframe first, then any lost range it closes.
  task automatic process_track_sample(input tbp_pkg::item_t smp);
    tbp_pkg::box_t    cur;
    tbp_pkg::box_t    shown;
    longint           wgt;
    logic [tbp_pkg::STRIDE_W:0] stride_eff;
    logic             lost;
    logic             key;
    tbp_pkg::result_t made[2];
    int               n;
    int               k;
    n = 0;
    lost = smp.score < regs.lost_threshold;
    // weights above one saturate at one; a zero stride acts as one
    wgt = (regs.smoothing_weight > tbp_pkg::Q_ONE) ? 65536
                                                   : longint'(regs.smoothing_weight);
    stride_eff = (regs.key_interval == '0) ? 17'd1 : {1'b0, regs.key_interval};

    if (track_open) begin
      seed_w = smp.box[tbp_pkg::LANE_W];
      seed_h = smp.box[tbp_pkg::LANE_H];
    end

    // every good sample refreshes the held box, hold enabled or not
    cur = smp.box;
    if (!lost) begin
      held_raw = smp.box;
      held_ok  = 1'b1;
    end else if (regs.hold_enable && held_ok) begin
      cur = held_raw;
    end

    // EMA with floor division; first sample of a track passes straight through
    for (k = 0; k < 4; k++) begin
      if (track_open)
        smooth_box[k] = cur[k];
      else
        smooth_box[k] = tbp_pkg::coord_t'(((65536 - wgt) * longint'($signed(cur[k]))
                                  + wgt * longint'($signed(smooth_box[k]))) >>> 16);
    end
    shown = smooth_box;
    if (!regs.track_size) begin
      shown[tbp_pkg::LANE_W] = seed_w;
      shown[tbp_pkg::LANE_H] = seed_h;
    end

    // a stride lowered below the phase gives no keyframe and wraps the phase
    key = (kf_phase == '0) || smp.final_sample;
    kf_phase = (({1'b0, kf_phase} + 17'd1) >= stride_eff) ? '0 : kf_phase + 1'b1;

    if (key) begin
      made[n].kind        = tbp_pkg::KIND_KEY;
      made[n].frame_start = smp.frame_number;
      made[n].frame_end   = '0;
      made[n].box         = shown;
      made[n].run_last    = 1'b0;
      n++;
    end

    if (lost) begin
      if (!in_run) begin
        in_run    = 1'b1;
        run_first = smp.frame_number;
      end
      if (smp.final_sample) begin
        made[n].kind        = tbp_pkg::KIND_RANGE;
        made[n].frame_start = run_first;
        made[n].frame_end   = smp.frame_number;
        made[n].box         = '0;
        made[n].run_last    = 1'b0;
        n++;
      end
    end else if (in_run) begin
      // run ended by a good sample: it stops at the previous frame
      made[n].kind        = tbp_pkg::KIND_RANGE;
      made[n].frame_start = run_first;
      made[n].frame_end   = last_frame;
      made[n].box         = '0;
      made[n].run_last    = 1'b0;
      n++;
      in_run = 1'b0;
    end

    if (n > 0) made[n-1].run_last = 1'b1;
    for (k = 0; k < n; k++)
      outstanding_results.insert(outstanding_results.size(), made[k]);

    track_open = 1'b0;
    last_frame = smp.frame_number;
    // the final sample returns the track state to reset, registers kept
    if (smp.final_sample) begin
      held_raw   = '0;
      held_ok    = 1'b0;
      smooth_box = '0;
      seed_w     = '0;
      seed_h     = '0;
      kf_phase   = '0;
      track_open = 1'b1;
      in_run     = 1'b0;
      run_first  = '0;
      last_frame = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers; all are entered and left at a falling edge
  // --------------------------------------------------------------------------

  // Offer one sample and hold it until the transaction completes. Bursts of
  // random length are separated by random gaps, some bursts back to back.
  task automatic send_sample(input logic [tbp_pkg::FRAME_W-1:0] fr,
                             input tbp_pkg::coord_t x, input tbp_pkg::coord_t y,
                             input tbp_pkg::coord_t w, input tbp_pkg::coord_t h,
                             input logic [tbp_pkg::SCORE_W-1:0] sc, input logic fin);
    int             gap;
    tbp_pkg::item_t smp;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    smp.frame_number         = fr;
    smp.box[tbp_pkg::LANE_X] = x;
    smp.box[tbp_pkg::LANE_Y] = y;
    smp.box[tbp_pkg::LANE_W] = w;
    smp.box[tbp_pkg::LANE_H] = h;
    smp.score                = sc;
    smp.final_sample         = fin;
    frame_number = smp.frame_number;
    box_x        = x;
    box_y        = y;
    box_w        = w;
    box_h        = h;
    score        = sc;
    final_sample = fin;
    in_valid     = 1'b1;
    // wait for the edge that takes the transaction
    do @(posedge clk); while (in_stall);
    process_track_sample(smp);
    @(negedge clk);
  endtask

  // Drop valid, let every expected result drain, then let any sample that
  // causes no result clear the pipeline before registers are touched.
  task automatic settle();
    in_valid = 1'b0;
    while (outstanding_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input tbp_pkg::reg_idx_e idx,
                           input logic [tbp_pkg::CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      tbp_pkg::REG_LOST_THRESHOLD:   regs.lost_threshold   = data;
      tbp_pkg::REG_HOLD_ENABLE:      regs.hold_enable      = data[0];
      tbp_pkg::REG_SMOOTHING_WEIGHT: regs.smoothing_weight = data;
      tbp_pkg::REG_TRACK_SIZE:       regs.track_size       = data[0];
      tbp_pkg::REG_KEY_INTERVAL:     regs.key_interval     = data[tbp_pkg::STRIDE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [tbp_pkg::SCORE_W-1:0] thr, input logic hold,
                            input logic [tbp_pkg::SCORE_W-1:0] wgt, input logic fol,
                            input logic [tbp_pkg::STRIDE_W-1:0] stride);
    write_reg(tbp_pkg::REG_LOST_THRESHOLD, thr);
    write_reg(tbp_pkg::REG_HOLD_ENABLE, {16'd0, hold});
    write_reg(tbp_pkg::REG_SMOOTHING_WEIGHT, wgt);
    write_reg(tbp_pkg::REG_TRACK_SIZE, {16'd0, fol});
    write_reg(tbp_pkg::REG_KEY_INTERVAL, {1'b0, stride});
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: held box over a lost run, run closed by a good sample,
  // score exactly at the threshold, extreme frames, boxes and scores.
  task automatic test_hold_and_ranges();
    send_sample(24'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000, 32'shFFFF_0000,
                17'd65536, 1'b0);
    send_sample(24'd1, 32'sh1234_5678, 32'shDEAD_BEEF, 32'sh0000_0001, 32'sh7FFF_FFFF,
                17'd0, 1'b0);
    send_sample(24'd2, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 32'sh0000_0000,
                17'd32767, 1'b0);
    send_sample(24'd3, 32'sh0000_0000, 32'shFFFF_FFFF, 32'sh8000_0000, 32'sh0F0F_0F0F,
                17'd32768, 1'b0);
    send_sample(24'hFF_FFFF, 32'shF0F0_F0F0, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh3333_3333,
                17'd131071, 1'b1);
  endtask

  // Hold off, size pinned, full weight: a lost sample opening the track keeps
  // its raw box, and a lost final sample reports a run of one frame.
  task automatic test_pinned_size_full_weight();
    settle();
    set_config(17'd32768, 1'b0, 17'd65536, 1'b0, 16'd0);
    send_sample(24'd5, 32'sh0010_0000, 32'sh0020_0000, 32'sh0030_0000, 32'sh0040_0000,
                17'd0, 1'b0);
    send_sample(24'd6, 32'sh7000_0000, 32'sh9000_0000, 32'sh0000_1000, 32'sh0000_2000,
                17'd100, 1'b0);
    send_sample(24'd7, 32'shFFF0_0000, 32'sh0001_8000, 32'sh0050_0000, 32'sh0060_0000,
                17'd65535, 1'b0);
    send_sample(24'd8, 32'sh1111_1111, 32'sh2222_2222, 32'sh4444_4444, 32'sh6666_6666,
                17'd1, 1'b1);
  endtask

  // Keyframe stride, weight above one, zero threshold, and a stride lowered
  // while the phase already sits at or past the new value.
  task automatic test_stride();
    settle();
    set_config(17'd0, 1'b1, 17'd131071, 1'b1, 16'd3);
    send_sample(24'd20, 32'sh0100_0000, 32'sh0200_0000, 32'sh0010_0000, 32'sh0020_0000,
                17'd0, 1'b0);
    send_sample(24'd21, 32'sh0180_0000, 32'sh0280_0000, 32'sh0018_0000, 32'sh0028_0000,
                17'd40000, 1'b0);
    settle();
    write_reg(tbp_pkg::REG_KEY_INTERVAL, 17'd2);
    send_sample(24'd22, 32'sh0190_0000, 32'sh0290_0000, 32'sh0019_0000, 32'sh0029_0000,
                17'd50000, 1'b0);
    settle();
    write_reg(tbp_pkg::REG_SMOOTHING_WEIGHT, 17'd16384);
    send_sample(24'd23, 32'shFF00_0000, 32'shFE00_0000, 32'sh0020_0000, 32'sh0030_0000,
                17'd60000, 1'b0);
    send_sample(24'd24, 32'sh0000_8000, 32'shFFFF_8000, 32'sh0021_0000, 32'sh0031_0000,
                17'd1, 1'b1);
  endtask

  // Threshold above one: full score is lost, only the top code is good;
  // widest stride leaves keyframes at the track start and the final sample.
  task automatic test_threshold_extremes();
    settle();
    set_config(17'd131071, 1'b1, 17'd32768, 1'b1, 16'd65535);
    send_sample(24'd100, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000,
                17'd65536, 1'b0);
    send_sample(24'd101, 32'sh8000_0001, 32'sh7FFF_FFFE, 32'sh0005_0000, 32'sh0006_0000,
                17'd131071, 1'b0);
    send_sample(24'd102, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000,
                17'd0, 1'b1);
  endtask

  // Random tracks under a fixed register setting per phase. Most of the
  // stimulus is well-formed tracks: steadily advancing frames, drifting boxes
  // and alternating good and lost stretches. One pick in ten is a single noise item.
  task automatic test_random_tracks();
    int   phase_no;
    int   placed;
    int   len;
    int   i;
    int   k;
    logic [tbp_pkg::SCORE_W-1:0] thr;
    logic [tbp_pkg::SCORE_W-1:0] sc;
    logic [tbp_pkg::FRAME_W-1:0] fr;
    tbp_pkg::box_t pos;
    logic dropping;
    for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
      settle();
      case (phase_no)
        0: set_config(17'd32768, 1'b1, 17'd0, 1'b1, 16'd1);
        1: set_config(17'd65536, 1'b0, 17'd65536, 1'b0, 16'd0);
        2: set_config(17'd131071, 1'b1, 17'd131071, 1'b1, 16'd65535);
        3: set_config(17'd0, 1'b0, 17'd1, 1'b0, 16'd2);
        default: set_config(17'($urandom_range(1, 65536)), 1'($urandom_range(0, 1)),
                            17'($urandom_range(0, 65536)), 1'($urandom_range(0, 1)),
                            16'($urandom_range(1, 8)));
      endcase
      thr = regs.lost_threshold;
      placed = 0;
      while (placed < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          send_sample(tbp_pkg::FRAME_W'($urandom), $urandom, $urandom, $urandom, $urandom,
                      tbp_pkg::SCORE_W'($urandom_range(0, 131071)),
                      $urandom_range(0, 7) == 0);
          placed++;
        end else begin
          // mostly short tracks, now and then a long one
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 20);
          fr = tbp_pkg::FRAME_W'($urandom);
          for (k = 0; k < 4; k++) pos[k] = $urandom;
          dropping = 1'b0;
          for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 5) == 0) dropping = !dropping;
            if (dropping && thr != '0)
              sc = tbp_pkg::SCORE_W'($urandom_range(0, thr - 1));
            else if (thr <= tbp_pkg::Q_ONE)
              sc = tbp_pkg::SCORE_W'($urandom_range(thr, 65536));
            else
              sc = tbp_pkg::SCORE_W'($urandom_range(thr, 131071));
            // drift the box, with an occasional jump
            for (k = 0; k < 4; k++) begin
              if ($urandom_range(0, 15) == 0)
                pos[k] = $urandom;
              else
                pos[k] = pos[k] + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            end
            send_sample(fr, pos[tbp_pkg::LANE_X], pos[tbp_pkg::LANE_Y],
                        pos[tbp_pkg::LANE_W], pos[tbp_pkg::LANE_H], sc, i == len - 1);
            fr = fr + tbp_pkg::FRAME_W'($urandom_range(1, 3));
          end
          placed += len;
        end
      end
    end
  endtask

  // The receiver holds off for a long stretch while samples keep coming
  // back to back, so the result queue fills and the input stalls.
  task automatic test_output_hold_off();
    int i;
    logic [tbp_pkg::FRAME_W-1:0] fr;
    settle();
    set_config(17'd32768, 1'b1, 17'd8192, 1'b1, 16'd1);
    fr = tbp_pkg::FRAME_W'($urandom);
    hold_off_asks++;
    burst_left = HOLD_OFF_ITEMS + 1;
    for (i = 0; i < HOLD_OFF_ITEMS; i++) begin
      // lost, lost, good: every third sample closes a run and gives two results
      send_sample(fr, $urandom, $urandom, $urandom, $urandom,
                  (i % 3 == 2) ? 17'd65536 : 17'd0, i == HOLD_OFF_ITEMS - 1);
      fr++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall on a pattern of its own, switching mode every so often,
  // and honour a long hold-off when one is asked for
  // --------------------------------------------------------------------------
  initial begin
    stall_mode_e mode;
    int mode_left;
    int hold_left;
    int tick;
    int asks_seen;
    mode      = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    asks_seen = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_off_asks != asks_seen) begin
        asks_seen = hold_off_asks;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          STALL_NONE:     out_stall = 1'b0;
          STALL_LIGHT:    out_stall = ($urandom_range(0, 3) == 0);
          STALL_HEAVY:    out_stall = ($urandom_range(0, 3) != 0);
          STALL_PERIODIC: out_stall = ((tick % 5) < 2);
          default:        out_stall = 1'b0;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checking against the oldest outstanding expectation
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %h, got %h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (outstanding_results.size() == 0) begin
        $error("result with nothing outstanding: kind %b frame_start %h", kind, frame_start);
        mismatches++;
      end else begin
        got_want = outstanding_results.pop_front();
        check_field("kind", 32'(got_want.kind), 32'(kind));
        check_field("frame_start", 32'(got_want.frame_start), 32'(frame_start));
        check_field("frame_end", 32'(got_want.frame_end), 32'(frame_end));
        check_field("out_x", got_want.box[tbp_pkg::LANE_X], out_x);
        check_field("out_y", got_want.box[tbp_pkg::LANE_Y], out_y);
        check_field("out_w", got_want.box[tbp_pkg::LANE_W], out_w);
        check_field("out_h", got_want.box[tbp_pkg::LANE_H], out_h);
        check_field("run_last", 32'(got_want.run_last), 32'(run_last));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_hold_and_ranges();
    test_pinned_size_full_weight();
    test_stride();
    test_threshold_extremes();
    test_random_tracks();
    test_output_hold_off();

    // drain everything, then give the pipeline time to show strays
    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
